[design/mqtt_fixed_header_codec_assert.svh]
// Assertion macros used by the checker of the header codec.
`ifndef MQTT_FIXED_HEADER_CODEC_ASSERT_SVH
`define MQTT_FIXED_HEADER_CODEC_ASSERT_SVH

// Same-cycle implication, disabled during reset
`define MFHC_ASSERT_IMP(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled during reset
`define MFHC_ASSERT_NXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

[design/mfhc_pkg.sv]
`default_nettype none

package mfhc_pkg;

  // Length field geometry
  localparam int MAX_LENGTH_DIGITS = 4;
  localparam int LEN_W             = 28;
  localparam int DIGIT_W           = 7;
  localparam int CNT_W             = 3;
  localparam int SHAMT_W           = 5;
  localparam logic [LEN_W-1:0] LEN_MAX =
    LEN_W'((64'd1 << (DIGIT_W * MAX_LENGTH_DIGITS)) - 64'd1);

  // Stream widths
  localparam int S_DATA_W = 48;
  localparam int M_DATA_W = 48;

  // Input selector codes (s_axis_tuser)
  localparam logic FUNC_DECODE = 1'b0;
  localparam logic FUNC_ENCODE = 1'b1;

  // Result kind codes (m_axis_tuser)
  localparam logic KIND_BYTE   = 1'b0;
  localparam logic KIND_HEADER = 1'b1;

  // Controller to datapath commands
  typedef struct packed {
    logic dec_take;
    logic enc_take;
    logic digit_emit;
  } ctrl_cmd_t;

  // Datapath to controller status
  typedef struct packed {
    logic out_free;
    logic digit_last;
  } dp_sts_t;

endpackage

`default_nettype wire

[design/mqtt_fixed_header_codec.sv]
// MQTT fixed header codec: header byte plus remaining-length varint.
// Input stream s_axis: tuser selects decode (0) or encode (1). A decode
// transaction carries one received header byte; an encode transaction
// carries type, flags and remaining length.
// Output stream m_axis: tuser 0 is an encoded byte (tlast on the final
// length byte), tuser 1 is one decoded header with length, byte count
// and malformed flag.
// An accepted transaction places its first result in the output register
// in the following cycle. Decode takes one byte per cycle while not
// stalled; the header byte of a frame emits nothing, the byte that ends
// the length emits one header. Encode emits 2 to 5 output bytes, one per
// cycle while not stalled, the length bytes from the digit shifter, and
// s_axis_tready stays low until the last byte has been loaded.
// Stalls: a held result stays in the output register; s_axis_tready is
// low while that register is full and not being taken.
// Reset (rst, synchronous): decoder expects a new header byte, length and
// count clear, output register empties.
`default_nettype none

module mqtt_fixed_header_codec (
  input  wire                               clk,
  input  wire                               rst,
  input  wire                               s_axis_tvalid,
  output logic                              s_axis_tready,
  // rx_byte[7:0], pkt_type[11:8], pkt_flags[15:12], remaining_len[43:16], zero pad
  input  wire  [mfhc_pkg::S_DATA_W-1:0]     s_axis_tdata,
  // func
  input  wire                               s_axis_tuser,
  output logic                              m_axis_tvalid,
  input  wire                               m_axis_tready,
  // out_byte[7:0], hdr_type[11:8], hdr_flags[15:12], decoded_length[43:16],
  // length_bytes[46:44], malformed[47]
  output logic [mfhc_pkg::M_DATA_W-1:0]     m_axis_tdata,
  // result_kind
  output logic                              m_axis_tuser,
  // last_byte
  output logic                              m_axis_tlast
);

  mfhc_pkg::ctrl_cmd_t cmd;
  mfhc_pkg::dp_sts_t   sts;

  mfhc_ctrl u_ctrl (
    .clk        (clk),
    .rst        (rst),
    .item_valid (s_axis_tvalid),
    .item_func  (s_axis_tuser),
    .sts        (sts),
    .item_ready (s_axis_tready),
    .cmd        (cmd)
  );

  mfhc_dp u_dp (
    .clk           (clk),
    .rst           (rst),
    .cmd           (cmd),
    .rx_byte       (s_axis_tdata[7:0]),
    .pkt_type      (s_axis_tdata[11:8]),
    .pkt_flags     (s_axis_tdata[15:12]),
    .remaining_len (s_axis_tdata[43:16]),
    .out_ready     (m_axis_tready),
    .sts           (sts),
    .out_valid     (m_axis_tvalid),
    .out_kind      (m_axis_tuser),
    .out_last      (m_axis_tlast),
    .out_data      (m_axis_tdata)
  );

endmodule

`default_nettype wire

[design/mfhc_ctrl.sv]
`default_nettype none

module mfhc_ctrl (
  input  wire                  clk,
  input  wire                  rst,
  input  wire                  item_valid,
  input  wire                  item_func,
  input  wire mfhc_pkg::dp_sts_t sts,
  output logic                 item_ready,
  output mfhc_pkg::ctrl_cmd_t  cmd
);

  localparam logic ST_IDLE = 1'b0;
  localparam logic ST_ENC  = 1'b1;

  logic state;
  logic state_next;

  // Take a new item only when idle and the output register can be refilled
  assign item_ready = (state == ST_IDLE) && sts.out_free;

  always_comb begin
    cmd.dec_take   = item_ready && item_valid && (item_func == mfhc_pkg::FUNC_DECODE);
    cmd.enc_take   = item_ready && item_valid && (item_func == mfhc_pkg::FUNC_ENCODE);
    cmd.digit_emit = (state == ST_ENC) && sts.out_free;
  end

  // Next state
  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (cmd.enc_take) begin
          state_next = ST_ENC;
        end
      end
      ST_ENC: begin
        if (cmd.digit_emit && sts.digit_last) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

endmodule

`default_nettype wire

[design/mfhc_dp.sv]
`default_nettype none

module mfhc_dp (
  input  wire                                  clk,
  input  wire                                  rst,
  input  wire mfhc_pkg::ctrl_cmd_t             cmd,
  input  wire  [7:0]                           rx_byte,
  input  wire  [3:0]                           pkt_type,
  input  wire  [3:0]                           pkt_flags,
  input  wire  [mfhc_pkg::LEN_W-1:0]           remaining_len,
  input  wire                                  out_ready,
  output mfhc_pkg::dp_sts_t                    sts,
  output logic                                 out_valid,
  output logic                                 out_kind,
  output logic                                 out_last,
  output logic [mfhc_pkg::M_DATA_W-1:0]        out_data
);

  // Decode state
  logic                          phase;
  logic [3:0]                    held_type;
  logic [3:0]                    held_flags;
  logic [mfhc_pkg::LEN_W-1:0]    length_accum;
  logic [mfhc_pkg::CNT_W-1:0]    digit_count;

  // Encode digit shifter
  logic [mfhc_pkg::LEN_W-1:0]    enc_len;

  // Output register payload
  logic [7:0]                    o_byte;
  logic [3:0]                    o_type;
  logic [3:0]                    o_flags;
  logic [mfhc_pkg::LEN_W-1:0]    o_len;
  logic [mfhc_pkg::CNT_W-1:0]    o_cnt;
  logic                          o_bad;

  logic [mfhc_pkg::CNT_W-1:0]    cnt_clip;
  logic [mfhc_pkg::CNT_W-1:0]    cnt_new;
  logic [mfhc_pkg::SHAMT_W-1:0]  shamt;
  logic [mfhc_pkg::LEN_W-1:0]    accum_new;
  logic                          dec_done;
  logic [mfhc_pkg::LEN_W-1:0]    len_sat;
  logic [mfhc_pkg::LEN_W-1:0]    enc_rest;
  logic                          digit_last;
  logic [7:0]                    digit_byte;

  // Status to the controller
  assign sts = '{out_free: (!out_valid || out_ready), digit_last: digit_last};

  // Length digit accumulation, least significant digit first
  always_comb begin
    cnt_clip = digit_count;
    if (digit_count >= mfhc_pkg::CNT_W'(mfhc_pkg::MAX_LENGTH_DIGITS)) begin
      cnt_clip = mfhc_pkg::CNT_W'(mfhc_pkg::MAX_LENGTH_DIGITS - 1);
    end
    cnt_new   = cnt_clip + mfhc_pkg::CNT_W'(1);
    shamt     = mfhc_pkg::SHAMT_W'(mfhc_pkg::DIGIT_W) * mfhc_pkg::SHAMT_W'(cnt_clip);
    accum_new = length_accum
              + (mfhc_pkg::LEN_W'(rx_byte[mfhc_pkg::DIGIT_W-1:0]) << shamt);
    dec_done  = !rx_byte[7]
              || (cnt_new >= mfhc_pkg::CNT_W'(mfhc_pkg::MAX_LENGTH_DIGITS));
  end

  // Encode: saturate, then peel one base-128 digit per byte
  always_comb begin
    len_sat    = (remaining_len > mfhc_pkg::LEN_MAX) ? mfhc_pkg::LEN_MAX : remaining_len;
    enc_rest   = enc_len >> mfhc_pkg::DIGIT_W;
    digit_last = (enc_rest == '0);
    digit_byte = {!digit_last, enc_len[mfhc_pkg::DIGIT_W-1:0]};
  end

  // Decode state registers
  always_ff @(posedge clk) begin
    if (rst) begin
      phase        <= 1'b0;
      held_type    <= '0;
      held_flags   <= '0;
      length_accum <= '0;
      digit_count  <= '0;
    end else if (cmd.dec_take) begin
      if (!phase) begin
        held_type    <= rx_byte[7:4];
        held_flags   <= rx_byte[3:0];
        length_accum <= '0;
        digit_count  <= '0;
        phase        <= 1'b1;
      end else begin
        length_accum <= accum_new;
        digit_count  <= cnt_new;
        if (dec_done) begin
          phase <= 1'b0;
        end
      end
    end
  end

  // Encode shifter
  always_ff @(posedge clk) begin
    if (cmd.enc_take) begin
      enc_len <= len_sat;
    end else if (cmd.digit_emit) begin
      enc_len <= enc_rest;
    end
  end

  // Output register valid
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.enc_take || cmd.digit_emit || (cmd.dec_take && phase && dec_done)) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  // Output register payload
  always_ff @(posedge clk) begin
    if (cmd.enc_take) begin
      out_kind <= mfhc_pkg::KIND_BYTE;
      out_last <= 1'b0;
      o_byte   <= {pkt_type, pkt_flags};
      o_type   <= '0;
      o_flags  <= '0;
      o_len    <= '0;
      o_cnt    <= '0;
      o_bad    <= 1'b0;
    end else if (cmd.digit_emit) begin
      out_kind <= mfhc_pkg::KIND_BYTE;
      out_last <= digit_last;
      o_byte   <= digit_byte;
      o_type   <= '0;
      o_flags  <= '0;
      o_len    <= '0;
      o_cnt    <= '0;
      o_bad    <= 1'b0;
    end else if (cmd.dec_take && phase && dec_done) begin
      out_kind <= mfhc_pkg::KIND_HEADER;
      out_last <= 1'b0;
      o_byte   <= '0;
      o_type   <= held_type;
      o_flags  <= held_flags;
      o_len    <= accum_new;
      o_cnt    <= cnt_new;
      o_bad    <= rx_byte[7];
    end
  end

  assign out_data = {o_bad, o_cnt, o_len, o_flags, o_type, o_byte};

endmodule

`default_nettype wire

[design/mfhc_checker.sv]
`default_nettype none
`include "mqtt_fixed_header_codec_assert.svh"

module mfhc_checker (
  input wire                            clk,
  input wire                            rst,
  input wire                            s_axis_tvalid,
  input wire                            s_axis_tready,
  input wire [mfhc_pkg::S_DATA_W-1:0]   s_axis_tdata,
  input wire                            s_axis_tuser,
  input wire                            m_axis_tvalid,
  input wire                            m_axis_tready,
  input wire [mfhc_pkg::M_DATA_W-1:0]   m_axis_tdata,
  input wire                            m_axis_tuser,
  input wire                            m_axis_tlast
);

  // Handshake and result terms
  logic                              out_stall;
  logic [mfhc_pkg::M_DATA_W+1:0]     out_word;
  logic                              enc_accept;
  logic                              enc_open;
  logic                              hdr_bad;
  logic [mfhc_pkg::CNT_W-1:0]        hdr_cnt;

  assign out_stall  = m_axis_tvalid && !m_axis_tready;
  assign out_word   = {m_axis_tdata, m_axis_tuser, m_axis_tlast};
  assign enc_accept = s_axis_tvalid && s_axis_tready && (s_axis_tuser == mfhc_pkg::FUNC_ENCODE);
  assign enc_open   = m_axis_tvalid && (m_axis_tuser == mfhc_pkg::KIND_BYTE) && !m_axis_tlast;
  assign hdr_bad    = m_axis_tvalid && (m_axis_tuser == mfhc_pkg::KIND_HEADER)
                    && m_axis_tdata[47];
  assign hdr_cnt    = m_axis_tdata[46:44];

  // Stalled result holds
  `MFHC_ASSERT_NXT(a_out_hold, clk, rst, out_stall,
    m_axis_tvalid && $stable(out_word), "stalled result changed")

  // Encode transaction shows its header byte next cycle, never as last
  `MFHC_ASSERT_NXT(a_enc_first, clk, rst, enc_accept, enc_open, "encode header byte missing")

  // Input blocked while an encoded header is partly out
  `MFHC_ASSERT_IMP(a_enc_busy, clk, rst, enc_open, !s_axis_tready, "input taken during encode")

  // Malformed header used every allowed length byte
  `MFHC_ASSERT_IMP(a_malformed_cnt, clk, rst, hdr_bad,
    hdr_cnt == mfhc_pkg::CNT_W'(mfhc_pkg::MAX_LENGTH_DIGITS), "malformed with short count")

endmodule

bind mqtt_fixed_header_codec mfhc_checker u_checker (.*);

`default_nettype wire
